>>> src/cars_pkg.sv
// ----------------------------------------------------------------------------
// cars_pkg: shared types and constants
// Types and register codes for the cave smoothing row stepper.
// ----------------------------------------------------------------------------
package cars_pkg;

  localparam int ROW_W      = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int COUNT_W    = 4;
  localparam int THRESH_W   = 4;
  localparam int WIDTH_W    = 7;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SURVIVE_MIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIRTH_MIN    = 2'd2;

  // Effective column bits one cell shows its neighbors: rows above, middle
  // and below for the first and the second result of a beat
  typedef struct packed {
    logic a1;
    logic m1;
    logic b1;
    logic a2;
    logic m2;
    logic b2;
  } col_t;

  localparam col_t COL_OUTSIDE = '{a1: 1'b1, m1: 1'b1, b1: 1'b1,
                                   a2: 1'b1, m2: 1'b1, b2: 1'b1};

  // One result row waiting for the output side
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic             done;
  } entry_t;

endpackage

>>> src/cave_automaton_row_step.sv
// ----------------------------------------------------------------------------
// cave_automaton_row_step: one pass of the 4-5 cave smoothing rule
// Streams a frame row by row through a row of column cells and a small
// result queue.
// ----------------------------------------------------------------------------
//   channel   direction  payload                          beat
//   s_*       in         tdata row_bits, tlast is_last_row  one input row
//   m_*       out        tdata out_row, tlast frame_done    one result row
//   cfg_*     in         cfg_index, cfg_wdata               one register write
//
// One row per cycle in while s_tready is high; each cell computes its column
// in the same cycle and the results land in a three-entry queue. A last row
// after other rows gives two results, so the output port (one row per beat)
// sets the rate: one-result rows pass at one per cycle while m_tready holds.
// Reset clears the queue and the held-row count; row bits need no reset.
// s_tready drops only while the queue holds two or more rows.
// ----------------------------------------------------------------------------
module cave_automaton_row_step #(
  parameter int MAX_WIDTH = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [cars_pkg::ROW_W-1:0]         s_tdata,   // [63:0] row_bits
  input  logic                               s_tlast,   // is_last_row
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [cars_pkg::ROW_W-1:0]         m_tdata,   // [63:0] out_row
  output logic                               m_tlast,   // frame_done
  input  logic                               cfg_we,
  input  logic [cars_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cars_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import cars_pkg::*;

  logic [WIDTH_W-1:0]  width_in_use;
  logic [THRESH_W-1:0] survive_min;
  logic [THRESH_W-1:0] birth_min;
  logic [1:0]          held;
  logic                accept;
  logic [1:0]          push_n;
  logic [ROW_W-1:0]    res1_row;
  logic [ROW_W-1:0]    res2_row;
  entry_t              d0;
  entry_t              d1;
  col_t                cols [MAX_WIDTH];

  assign accept = s_tvalid & s_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      width_in_use <= WIDTH_W'(50);
      survive_min  <= THRESH_W'(4);
      birth_min    <= THRESH_W'(5);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH_IN_USE: width_in_use <= cfg_wdata;
        REG_SURVIVE_MIN:  survive_min  <= cfg_wdata[THRESH_W-1:0];
        REG_BIRTH_MIN:    birth_min    <= cfg_wdata[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // Track how many rows are pending above the next one
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 2'd0;
    end else if (accept) begin
      if (s_tlast) begin
        held <= 2'd0;
      end else if (held == 2'd0) begin
        held <= 2'd1;
      end else begin
        held <= 2'd2;
      end
    end
  end

  // Row of column cells, each seeing its neighbors' bits
  for (genvar i = 0; i < ROW_W; i++) begin : g_col
    if (i < MAX_WIDTH) begin : g_cell
      col_t left;
      col_t right;
      if (i == 0) begin : g_lb
        assign left = COL_OUTSIDE;
      end else begin : g_ln
        assign left = cols[i-1];
      end
      if (i == MAX_WIDTH - 1) begin : g_rb
        assign right = COL_OUTSIDE;
      end else begin : g_rn
        assign right = cols[i+1];
      end
      cars_cell #(.IDX(i)) u_cell (
        .clk          (clk),
        .load         (accept),
        .row_bit      (s_tdata[i]),
        .held         (held),
        .width_in_use (width_in_use),
        .survive_min  (survive_min),
        .birth_min    (birth_min),
        .left         (left),
        .right        (right),
        .col          (cols[i]),
        .res1         (res1_row[i]),
        .res2         (res2_row[i])
      );
    end else begin : g_pad
      assign res1_row[i] = 1'b0;
      assign res2_row[i] = 1'b0;
    end
  end

  // Decide how many result rows this beat releases
  always_comb begin
    if (!accept) begin
      push_n = 2'd0;
    end else if (held == 2'd0) begin
      push_n = s_tlast ? 2'd1 : 2'd0;
    end else begin
      push_n = s_tlast ? 2'd2 : 2'd1;
    end
  end

  assign d0 = '{row: res1_row, done: (held == 2'd0)};
  assign d1 = '{row: res2_row, done: 1'b1};

  cars_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push_n   (push_n),
    .d0       (d0),
    .d1       (d1),
    .space    (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // A frame's last row always leaves a result waiting
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=> m_tvalid)
    else $error("last row accepted but no result pending");

  // A first row of a longer frame becomes the pending row
  a_first_row_held: assert property (@(posedge clk) disable iff (rst)
    (accept && !s_tlast && (held == 2'd0)) |=> (held == 2'd1))
    else $error("first row not held");

  // No more than two rows are ever pending
  a_held_range: assert property (@(posedge clk) disable iff (rst)
    held != 2'd3)
    else $error("held-row count out of range");

endmodule

>>> src/cars_cell.sv
// ----------------------------------------------------------------------------
// cars_cell: one column of the smoothing row
// Holds the column's bits of the two pending rows and applies the rule.
// ----------------------------------------------------------------------------
module cars_cell #(
  parameter int IDX = 0
) (
  input  logic                            clk,
  input  logic                            load,
  input  logic                            row_bit,
  input  logic [1:0]                      held,
  input  logic [cars_pkg::WIDTH_W-1:0]    width_in_use,
  input  logic [cars_pkg::THRESH_W-1:0]   survive_min,
  input  logic [cars_pkg::THRESH_W-1:0]   birth_min,
  input  cars_pkg::col_t                  left,
  input  cars_pkg::col_t                  right,
  output cars_pkg::col_t                  col,
  output logic                            res1,
  output logic                            res2
);
  import cars_pkg::*;

  localparam logic [WIDTH_W-1:0] COL_IDX = WIDTH_W'(IDX);

  logic               upper;
  logic               middle;
  logic               inside_frame;
  logic               outside;
  logic [COUNT_W-1:0] count1;
  logic [COUNT_W-1:0] count2;

  // Shift the pending rows down on every accepted beat
  always_ff @(posedge clk) begin
    if (load) begin
      upper  <= middle;
      middle <= row_bit;
    end
  end

  assign inside_frame = (width_in_use > COL_IDX);
  assign outside      = ~inside_frame;

  // Pick the rows of each result; rows outside the frame read as filled
  always_comb begin
    unique case (held)
      2'd0: begin
        col.a1 = 1'b1;
        col.m1 = row_bit | outside;
        col.b1 = 1'b1;
      end
      2'd1: begin
        col.a1 = 1'b1;
        col.m1 = middle | outside;
        col.b1 = row_bit | outside;
      end
      default: begin
        col.a1 = upper | outside;
        col.m1 = middle | outside;
        col.b1 = row_bit | outside;
      end
    endcase
    col.a2 = middle | outside;
    col.m2 = row_bit | outside;
    col.b2 = 1'b1;
  end

  // Count the eight neighbors of each result
  assign count1 = COUNT_W'(left.a1) + COUNT_W'(left.m1) + COUNT_W'(left.b1)
                + COUNT_W'(right.a1) + COUNT_W'(right.m1) + COUNT_W'(right.b1)
                + COUNT_W'(col.a1) + COUNT_W'(col.b1);
  assign count2 = COUNT_W'(left.a2) + COUNT_W'(left.m2) + COUNT_W'(left.b2)
                + COUNT_W'(right.a2) + COUNT_W'(right.m2) + COUNT_W'(right.b2)
                + COUNT_W'(col.a2) + COUNT_W'(col.b2);

  // Apply survive or birth threshold, zero outside the width in use
  assign res1 = inside_frame &
                (col.m1 ? (count1 >= survive_min) : (count1 >= birth_min));
  assign res2 = inside_frame &
                (col.m2 ? (count2 >= survive_min) : (count2 >= birth_min));

endmodule

>>> src/cars_outq.sv
// ----------------------------------------------------------------------------
// cars_outq: three-entry result queue
// Takes up to two result rows a cycle and hands out one per beat.
// ----------------------------------------------------------------------------
module cars_outq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [1:0]                    push_n,
  input  cars_pkg::entry_t              d0,
  input  cars_pkg::entry_t              d1,
  output logic                          space,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [cars_pkg::ROW_W-1:0]    m_tdata,   // [63:0] out_row
  output logic                          m_tlast    // frame_done
);
  import cars_pkg::*;

  localparam int DEPTH = 3;

  entry_t     slot [DEPTH];
  entry_t     slot_next [DEPTH];
  logic [1:0] count;
  logic [1:0] count_next;
  logic [1:0] cnt_after;
  logic       pop;

  assign pop      = m_tvalid & m_tready;
  assign m_tvalid = (count != 2'd0);
  assign m_tdata  = slot[0].row;
  assign m_tlast  = slot[0].done;
  // Room for two more rows
  assign space    = ~count[1];

  assign cnt_after  = count - {1'b0, pop};
  assign count_next = cnt_after + push_n;

  // Advance on pop, then drop new rows behind the remaining ones
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      slot_next[k] = slot[k];
    end
    if (pop) begin
      for (int k = 0; k < DEPTH - 1; k++) begin
        slot_next[k] = slot[k+1];
      end
    end
    for (int k = 0; k < DEPTH; k++) begin
      if ((push_n != 2'd0) && (cnt_after == 2'(k))) begin
        slot_next[k] = d0;
      end
      if ((push_n == 2'd2) && ((cnt_after + 2'd1) == 2'(k))) begin
        slot_next[k] = d1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DEPTH; k++) begin
      slot[k] <= slot_next[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

endmodule

>>> dv/cave_automaton_row_step_test.sv
// ----------------------------------------------------------------------------
// cave_automaton_row_step_test: self-checking bench for the cave smoother
// Streams frames of cell rows through the block under several register
// settings. A running row model works out the smoothed rows of each accepted
// beat, and every output beat is checked against the oldest of them. Both
// stream sides idle in random bursts, and the output side also holds off
// once for a long stretch so that the input backs up.
// ----------------------------------------------------------------------------
module cave_automaton_row_step_test;
  import cars_pkg::*;

  localparam int                    LIMIT_CYCLES = 200000;
  localparam int                    SETTLE_CYCLES = 8;
  localparam int                    HOLD_CYCLES = 300;
  localparam logic [CFG_IDX_W-1:0]  REG_SPARE = 2'd3;
  localparam logic [ROW_W-1:0]      ALL_FILLED = '1;

  typedef struct packed {
    logic [ROW_W-1:0] bits;
    logic             last;
  } row_beat_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic             done;
  } result_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [ROW_W-1:0]      s_tdata = '0;     // [63:0] row_bits
  logic                  s_tlast = 1'b0;   // is_last_row
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [ROW_W-1:0]      m_tdata;          // [63:0] out_row
  logic                  m_tlast;          // frame_done
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Model copy of the registers and of the held rows
  logic [WIDTH_W-1:0]    cols_used = 7'd50;
  logic [THRESH_W-1:0]   survive_at = 4'd4;
  logic [THRESH_W-1:0]   birth_at = 4'd5;
  logic [ROW_W-1:0]      row_above_q = '0;
  logic [ROW_W-1:0]      row_mid_q = '0;
  int                    held_cnt = 0;

  row_beat_t             frame_rows_q[$];
  result_t               smoothed_rows_q[$];
  int                    mismatch_cnt = 0;
  int                    cycle_cnt = 0;
  logic                  in_taken = 1'b0;
  logic                  calm = 1'b0;
  logic                  hold_arm = 1'b0;
  logic                  hold_used = 1'b0;
  int                    hold_left = 0;
  int                    send_gap = 0;
  int                    ready_gap = 0;

  cave_automaton_row_step u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // One smoothing step of a row given its neighbors; outside cells are filled
  function automatic logic [ROW_W-1:0] next_gen_row(input logic [ROW_W-1:0] above,
                                                   input logic [ROW_W-1:0] mid,
                                                   input logic [ROW_W-1:0] below);
    logic [ROW_W-1:0] lanes;
    logic [ROW_W+1:0] pa;
    logic [ROW_W+1:0] pm;
    logic [ROW_W+1:0] pb;
    logic [ROW_W-1:0] result;
    int               w;
    int               cnt;
    int               i;
    int               k;
    w = (cols_used > 7'd64) ? 64 : int'(cols_used);
    lanes = (w == 64) ? ALL_FILLED : ((64'd1 << w) - 64'd1);
    pa = {1'b1, above | ~lanes, 1'b1};
    pm = {1'b1, mid | ~lanes, 1'b1};
    pb = {1'b1, below | ~lanes, 1'b1};
    result = '0;
    for (i = 0; i < ROW_W; i++) begin
      cnt = 0;
      for (k = 0; k < 3; k++) begin
        cnt = cnt + pa[i+k] + pb[i+k];
      end
      cnt = cnt + pm[i] + pm[i+2];
      result[i] = pm[i+1] ? (cnt >= survive_at) : (cnt >= birth_at);
    end
    return result & lanes;
  endfunction

  function automatic void push_result(input logic [ROW_W-1:0] row, input logic done);
    result_t r;
    r.row = row;
    r.done = done;
    smoothed_rows_q = {smoothed_rows_q, r};
  endfunction

  // Advance the row window by one accepted beat and queue what it releases
  function automatic void take_row(input logic [ROW_W-1:0] bits, input logic last);
    logic [ROW_W-1:0] above;
    if (held_cnt == 0) begin
      if (last) begin
        push_result(next_gen_row(ALL_FILLED, bits, ALL_FILLED), 1'b1);
      end else begin
        row_mid_q = bits;
        held_cnt = 1;
      end
    end else begin
      above = (held_cnt == 1) ? ALL_FILLED : row_above_q;
      push_result(next_gen_row(above, row_mid_q, bits), 1'b0);
      row_above_q = row_mid_q;
      row_mid_q = bits;
      held_cnt = 2;
      if (last) begin
        push_result(next_gen_row(row_above_q, row_mid_q, ALL_FILLED), 1'b1);
        held_cnt = 0;
      end
    end
  endfunction

  // Sample both sides: predict on input beats, check output beats
  always @(posedge clk) begin : monitor
    result_t want;
    in_taken = 1'b0;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        in_taken = 1'b1;
        take_row(s_tdata, s_tlast);
      end
      if (m_tvalid && m_tready) begin
        if (smoothed_rows_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected beat: row %h done %b", m_tdata, m_tlast);
        end else begin
          want = smoothed_rows_q.pop_front();
          if (m_tdata !== want.row || m_tlast !== want.done) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch: expected row %h done %b, got row %h done %b",
                       want.row, want.done, m_tdata, m_tlast);
          end
        end
      end
    end
  end

  // Input side: next row after a beat is taken, with random gaps
  always @(negedge clk) begin : row_driver
    row_beat_t beat;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        send_gap <= $urandom_range(0, 6);
        s_tvalid <= 1'b0;
      end else if (frame_rows_q.size() != 0) begin
        beat = frame_rows_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= beat.bits;
        s_tlast <= beat.last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Long output hold-off, armed once
  always @(negedge clk) begin
    if (hold_arm && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Output side: ready with random stall bursts
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready <= 1'b0;
    end else if (ready_gap != 0) begin
      ready_gap <= ready_gap - 1;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      ready_gap <= $urandom_range(0, 6);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic add_row(input logic [ROW_W-1:0] bits, input logic last);
    row_beat_t beat;
    beat.bits = bits;
    beat.last = last;
    frame_rows_q = {frame_rows_q, beat};
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_WIDTH_IN_USE: cols_used = value;
      REG_SURVIVE_MIN:  survive_at = value[THRESH_W-1:0];
      REG_BIRTH_MIN:    birth_at = value[THRESH_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every row is sent and every result seen, then let it settle
  task automatic drain();
    while (frame_rows_q.size() != 0 || s_tvalid || smoothed_rows_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [ROW_W-1:0] cave_row(input int fill_pct);
    logic [ROW_W-1:0] bits;
    int               i;
    for (i = 0; i < ROW_W; i++)
      bits[i] = ($urandom_range(0, 99) < fill_pct);
    return bits;
  endfunction

  // Queue whole frames; some are followed by their own next pass
  task automatic queue_frames(input int row_goal);
    logic [ROW_W-1:0] frame[$];
    logic [ROW_W-1:0] pass[$];
    logic [ROW_W-1:0] above;
    logic [ROW_W-1:0] below;
    int               made;
    int               height;
    int               fill_pct;
    int               r;
    made = 0;
    while (made < row_goal) begin
      height = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      case ($urandom_range(0, 5))
        0:       fill_pct = 0;
        1:       fill_pct = 100;
        2:       fill_pct = 45;
        default: fill_pct = $urandom_range(0, 100);
      endcase
      frame.delete();
      for (r = 0; r < height; r++)
        frame = {frame, cave_row(fill_pct)};
      for (r = 0; r < height; r++)
        add_row(frame[r], r == height - 1);
      made += height;
      // feed the smoothed frame back in as a second pass
      if ($urandom_range(0, 2) == 0) begin
        pass.delete();
        for (r = 0; r < height; r++) begin
          above = (r == 0) ? ALL_FILLED : frame[r-1];
          below = (r == height - 1) ? ALL_FILLED : frame[r+1];
          pass = {pass, next_gen_row(above, frame[r], below)};
        end
        for (r = 0; r < height; r++)
          add_row(pass[r], r == height - 1);
        made += height;
      end
    end
  endtask

  initial begin : stimulus
    logic [WIDTH_W-1:0]  width_tab[8];
    logic [THRESH_W-1:0] survive_tab[8];
    logic [THRESH_W-1:0] birth_tab[8];
    logic [WIDTH_W-1:0]  w;
    logic [THRESH_W-1:0] sv;
    logic [THRESH_W-1:0] bn;
    int                  ph;

    width_tab   = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd65, 7'd2, 7'd63, 7'd50};
    survive_tab = '{4'd0, 4'd9, 4'd15, 4'd8, 4'd1, 4'd4, 4'd3, 4'd5};
    birth_tab   = '{4'd0, 4'd15, 4'd9, 4'd1, 4'd8, 4'd5, 4'd3, 4'd4};

    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frames under the reset settings
    add_row('0, 1'b1);                          // single empty row
    add_row(ALL_FILLED, 1'b1);                  // single filled row
    add_row('0, 1'b0);                          // two rows, empty over filled
    add_row(ALL_FILLED, 1'b1);
    add_row(64'h5555_5555_5555_5555, 1'b0);     // stripes and bits past width
    add_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    add_row(64'hFFFF_0000_0000_0000, 1'b1);
    add_row(64'h8002_0000_0000_0001, 1'b0);     // lone cells at the edges
    add_row(64'h0000_0000_0000_0000, 1'b0);
    add_row(64'h0003_FFFF_FFFF_FFFE, 1'b0);
    add_row(64'h0001_0000_0000_0001, 1'b1);
    add_row(64'h0000_0000_0000_0000, 1'b0);     // empty cave, three rows
    add_row(64'h0000_0000_0000_0000, 1'b0);
    add_row(64'h0000_0000_0000_0000, 1'b1);
    drain();

    // Sweep settings: extremes first, then random ones
    for (ph = 0; ph < 12; ph++) begin
      if (ph < 8) begin
        w = width_tab[ph];
        sv = survive_tab[ph];
        bn = birth_tab[ph];
      end else begin
        w = ($urandom_range(0, 5) == 0) ? WIDTH_W'($urandom_range(0, 127))
                                        : WIDTH_W'($urandom_range(1, 64));
        sv = ($urandom_range(0, 4) == 0) ? THRESH_W'($urandom_range(0, 15))
                                         : THRESH_W'($urandom_range(0, 9));
        bn = ($urandom_range(0, 4) == 0) ? THRESH_W'($urandom_range(0, 15))
                                         : THRESH_W'($urandom_range(0, 9));
      end
      write_reg(REG_WIDTH_IN_USE, w);
      write_reg(REG_SURVIVE_MIN, {3'($urandom_range(0, 7)), sv});
      write_reg(REG_BIRTH_MIN, {3'($urandom_range(0, 7)), bn});
      if (ph == 3)
        write_reg(REG_SPARE, 7'($urandom_range(0, 127)));
      @(posedge clk);
      if (ph == 1)
        hold_arm = 1'b1;
      if (ph == 11)
        calm = 1'b1;
      queue_frames(65);
      drain();
    end

    if (mismatch_cnt == 0 && smoothed_rows_q.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
